// ===== hw/rtl/npcp_pkg.sv =====
// Package for the nearest palette color pair block: widths, palette table,
// stage record and the squared difference helper. No dependencies.
package npcp_pkg;

  localparam int unsigned NUM_COLORS   = 8;
  localparam int unsigned COLOR_W      = $clog2(NUM_COLORS);
  localparam int unsigned PAIR_W       = 2 * COLOR_W;
  localparam int unsigned PALETTE_SIZE = 2 * NUM_COLORS;
  localparam int unsigned CH_W         = 8;
  localparam int unsigned SQ_W         = 2 * CH_W;
  localparam int unsigned DIST_W       = SQ_W + 2;

  localparam logic [COLOR_W-1:0] WHITE_INDEX = COLOR_W'(NUM_COLORS - 1);
  localparam logic [COLOR_W-1:0] BLACK_INDEX = '0;
  localparam logic [DIST_W-1:0]  DIST_MAX    = DIST_W'(3 * 255 * 255);

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [CH_W-1:0]    r;
    logic [CH_W-1:0]    g;
    logic [CH_W-1:0]    b;
  } pal_entry_t;

  localparam pal_entry_t PALETTE [PALETTE_SIZE] = '{
    '{3'd0, 8'h00, 8'h00, 8'h00}, '{3'd0, 8'hC0, 8'hC0, 8'hC0},
    '{3'd1, 8'h80, 8'h00, 8'h00}, '{3'd1, 8'hFF, 8'h00, 8'h00},
    '{3'd2, 8'h00, 8'h80, 8'h00}, '{3'd2, 8'h00, 8'hFF, 8'h00},
    '{3'd3, 8'h80, 8'h80, 8'h00}, '{3'd3, 8'hFF, 8'hFF, 8'h00},
    '{3'd4, 8'h00, 8'h00, 8'h80}, '{3'd4, 8'h00, 8'h00, 8'hFF},
    '{3'd5, 8'h80, 8'h00, 8'h80}, '{3'd5, 8'hFF, 8'h00, 8'hFF},
    '{3'd6, 8'h00, 8'h80, 8'h80}, '{3'd6, 8'h00, 8'hFF, 8'hFF},
    '{3'd7, 8'h80, 8'h80, 8'h80}, '{3'd7, 8'hFF, 8'hFF, 8'hFF}
  };

  typedef struct packed {
    logic [CH_W-1:0]    r;
    logic [CH_W-1:0]    g;
    logic [CH_W-1:0]    b;
    logic [COLOR_W-1:0] back;
    logic [COLOR_W-1:0] fore;
    logic               bold;
    logic               to_back;
    logic [DIST_W-1:0]  best;
  } npcp_stage_t;

  function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    logic [CH_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return {{CH_W{1'b0}}, d} * {{CH_W{1'b0}}, d};
  endfunction

endpackage

// ===== hw/rtl/npcp_if.sv =====
// Request and result channel interfaces of the nearest palette color pair block.
// Depends on npcp_pkg for field widths.
interface npcp_req_if import npcp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CH_W-1:0]    red;
  logic [CH_W-1:0]    green;
  logic [CH_W-1:0]    blue;
  logic [PAIR_W-1:0]  current_pair;
  logic               target_background;

  modport source (output valid, red, green, blue, current_pair, target_background,
                  input ready);
  modport sink   (input valid, red, green, blue, current_pair, target_background,
                  output ready);
endinterface

interface npcp_rsp_if import npcp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PAIR_W-1:0] new_pair;
  logic              bold;

  modport source (output valid, new_pair, bold, input ready);
  modport sink   (input valid, new_pair, bold, output ready);
endinterface

// ===== hw/rtl/npcp_cell.sv =====
// One cell of the palette search chain: compares the request against one
// palette entry and hands the running best on. Depends on npcp_pkg.
module npcp_cell import npcp_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        valid_i,
  input  npcp_stage_t stage_i,
  output logic        valid_o,
  output npcp_stage_t stage_o
);

  localparam pal_entry_t ENTRY = PALETTE[IDX];
  localparam logic       ODD   = IDX[0];

  logic        valid_q;
  npcp_stage_t stage_d, stage_q;
  logic [DIST_W-1:0] dist_sq;

  always_comb begin
    dist_sq = DIST_W'(sq_diff(stage_i.r, ENTRY.r)) + DIST_W'(sq_diff(stage_i.g, ENTRY.g))
            + DIST_W'(sq_diff(stage_i.b, ENTRY.b));
    stage_d = stage_i;
    if (dist_sq < stage_i.best) begin
      stage_d.best = dist_sq;
      if (stage_i.to_back) begin
        stage_d.back = ENTRY.color;
      end else begin
        stage_d.fore = ENTRY.color;
        stage_d.bold = ODD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

  a_back_no_bold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && stage_q.to_back |-> !stage_q.bold)
    else $error("bold set on a background request");
  a_best_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> stage_q.best <= DIST_MAX)
    else $error("running best above largest distance");
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && valid_i |=> valid_q)
    else $error("request dropped in cell");

endmodule

// ===== hw/rtl/npcp_out_stage.sv =====
// Output stage: applies the same-color fix-up and holds the result register.
// Depends on npcp_pkg and npcp_rsp_if.
module npcp_out_stage import npcp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  npcp_stage_t stage_i,
  output logic        adv_o,
  npcp_rsp_if.source  rsp_o
);

  logic              valid_q;
  logic [PAIR_W-1:0] pair_d, pair_q;
  logic              bold_q;

  assign adv_o = !valid_q || rsp_o.ready;

  always_comb begin
    if (stage_i.bold || (stage_i.back != stage_i.fore)) begin
      pair_d = {stage_i.back, stage_i.fore};
    end else if (stage_i.fore != WHITE_INDEX) begin
      pair_d = {stage_i.back, WHITE_INDEX};
    end else begin
      pair_d = {stage_i.back, BLACK_INDEX};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      pair_q <= pair_d;
      bold_q <= stage_i.bold;
    end
  end

  assign rsp_o.valid    = valid_q;
  assign rsp_o.new_pair = pair_q;
  assign rsp_o.bold     = bold_q;

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_o && valid_i |=> valid_q)
    else $error("result lost at output register");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !rsp_o.ready |=> valid_q)
    else $error("stalled result dropped");
  a_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> bold_q || (pair_q[PAIR_W-1:COLOR_W] != pair_q[COLOR_W-1:0]))
    else $error("foreground equals background without bold");

endmodule

// ===== hw/rtl/nearest_palette_color_pair.sv =====
// Top level of the nearest palette color pair block: a chain of sixteen
// search cells followed by the output stage. Depends on npcp_pkg, npcp_if,
// npcp_cell and npcp_out_stage.
//
//  channel  dir  modport  payload
//  req_i    in   sink     red, green, blue, current_pair, target_background
//  rsp_o    out  source   new_pair, bold
//
// One request per cycle unless a stall on rsp_o holds the chain; a request
// passes the sixteen palette cell registers in order and then the output
// register. Each cell holds one palette compare. Reset clears the valid
// bits of the chain and the output register only. A stall on rsp_o freezes
// the whole chain; req_i.ready is low only while a result waits and rsp_o.ready is low.
module nearest_palette_color_pair import npcp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  npcp_req_if.sink   req_i,
  npcp_rsp_if.source rsp_o
);

  logic        adv;
  logic        valid [PALETTE_SIZE+1];
  npcp_stage_t stage [PALETTE_SIZE+1];

  assign req_i.ready = adv;
  assign valid[0]    = req_i.valid;

  always_comb begin
    stage[0].r       = req_i.red;
    stage[0].g       = req_i.green;
    stage[0].b       = req_i.blue;
    stage[0].back    = req_i.current_pair[PAIR_W-1:COLOR_W];
    stage[0].fore    = req_i.current_pair[COLOR_W-1:0];
    stage[0].bold    = 1'b0;
    stage[0].to_back = req_i.target_background;
    stage[0].best    = '1;
  end

  for (genvar i = 0; i < PALETTE_SIZE; i++) begin : g_cell
    npcp_cell #(.IDX(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (valid[i]),
      .stage_i (stage[i]),
      .valid_o (valid[i+1]),
      .stage_o (stage[i+1])
    );
  end

  npcp_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid[PALETTE_SIZE]),
    .stage_i (stage[PALETTE_SIZE]),
    .adv_o   (adv),
    .rsp_o   (rsp_o)
  );

endmodule
